[hdl/kmpp_pkg.sv]
// Shared types and constants for the periodic prefix detector.
package kmpp_pkg;

  localparam int MaxLen = 65536;
  localparam int CharAW = $clog2(MaxLen);
  localparam int AddrW = $clog2(MaxLen + 1);
  localparam int PosW = $clog2(MaxLen + 2);
  localparam int OutW = 17;
  localparam int QDepth = 2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       start_new;
  } in_beat_t;

  typedef struct packed {
    logic [OutW-1:0] prefix_length;
    logic            periodic;
    logic [OutW-1:0] repeat_count;
    logic            overflow;
  } out_beat_t;

  // Job passed from the front part to the back part.
  typedef struct packed {
    logic [7:0] symbol;
    logic       start_new;
  } job_t;

endpackage

[hdl/kmpp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module kmpp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/kmpp_front.sv]
// Front part: accepts input beats into a short queue towards the back part.
module kmpp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kmpp_pkg::in_beat_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output kmpp_pkg::job_t    job
);

  kmpp_pkg::job_t q_r [kmpp_pkg::QDepth];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic push, pop;

  assign in_ready  = (q_cnt_r != 2'(kmpp_pkg::QDepth));
  assign push      = in_valid && in_ready;
  assign job_valid = (q_cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[q_rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[q_wp_r].symbol    <= in_data.symbol;
      q_r[q_wp_r].start_new <= in_data.start_new;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/kmpp_div.sv]
// Iterative restoring divider: one quotient bit per cycle.
module kmpp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kmpp_pkg::PosW-1:0]  dividend,
  input  logic [kmpp_pkg::PosW-1:0]  divisor,
  output logic                       done,
  output logic [kmpp_pkg::PosW-1:0]  quotient,
  output logic [kmpp_pkg::PosW-1:0]  remainder
);

  localparam int W = kmpp_pkg::PosW;

  logic [W-1:0] q_r, r_r, d_r;
  logic [$clog2(W+1)-1:0] cnt_r;
  logic busy_r;
  logic [W:0] trial;

  assign trial     = {r_r, q_r[W-1]} - {1'b0, d_r};
  assign quotient  = q_r;
  assign remainder = r_r;

  // One shift-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
        cnt_r  <= ($clog2(W+1))'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!trial[W]) begin
          r_r <= trial[W-1:0];
          q_r <= {q_r[W-2:0], 1'b1};
        end else begin
          r_r <= {r_r[W-2:0], q_r[W-1]};
          q_r <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ($clog2(W+1))'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/kmpp_back.sv]
// Back part: failure-link walk, store update and period check per character.
module kmpp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  kmpp_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output kmpp_pkg::out_beat_t out_data
);

  localparam int CAW = kmpp_pkg::CharAW;
  localparam int AW = kmpp_pkg::AddrW;
  localparam int PW = kmpp_pkg::PosW;
  localparam int OW = kmpp_pkg::OutW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDC   = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_RDF   = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0] pos_r, k_r, len_r;
  logic [7:0] sym_r;
  logic out_valid_r;
  kmpp_pkg::out_beat_t out_r;

  logic c_we, f_we;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [7:0] c_wdata, c_rdata;
  logic [PW-1:0] f_wdata, f_rdata;
  logic div_start, div_done;
  logic [PW-1:0] div_q, div_r;
  logic [PW-1:0] kpos;
  logic first_take;
  logic [PW-1:0] match_k, upd_len, upd_per;

  kmpp_ram #(.Width(8), .Depth(kmpp_pkg::MaxLen)) u_char (
    .clk, .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
    .rd_addr(c_raddr), .rd_data(c_rdata)
  );

  kmpp_ram #(.Width(PW), .Depth(kmpp_pkg::MaxLen + 1)) u_fail (
    .clk, .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
    .rd_addr(f_raddr), .rd_data(f_rdata)
  );

  kmpp_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(upd_len), .divisor(upd_per),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // Position after an optional restart, used when a job is taken.
  assign kpos      = job.start_new ? '0 : pos_r;
  assign job_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The first character of a string is stored as soon as it is taken.
  assign first_take = (state_r == S_IDLE) && job_valid && job_ready && (kpos == '0);

  // Extended border, new length and shortest period for the update step.
  assign match_k = (c_rdata == sym_r) ? k_r + 1'b1 : '0;
  assign upd_len = pos_r + 1'b1;
  assign upd_per = upd_len - match_k;

  assign c_raddr   = k_r[CAW-1:0];
  assign f_raddr   = k_r[AW-1:0];
  assign c_we      = (state_r == S_UPD) || first_take;
  assign c_waddr   = first_take ? '0 : pos_r[CAW-1:0];
  assign c_wdata   = first_take ? job.symbol : sym_r;
  assign f_we      = c_we;
  assign f_waddr   = first_take ? AW'(1) : AW'(pos_r + 1'b1);
  assign f_wdata   = first_take ? '0 : match_k;
  assign div_start = (state_r == S_UPD);

  // Sequencer for one character.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (job_valid && job_ready && kpos < PW'(kmpp_pkg::MaxLen) && kpos != '0)
                 state_nxt = S_RDC;
      S_RDC:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (k_r != '0 && c_rdata != sym_r) ? S_RDF : S_UPD;
      S_RDF:   state_nxt = S_RDC;
      S_UPD:   state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            sym_r <= job.symbol;
            if (kpos >= PW'(kmpp_pkg::MaxLen)) begin
              pos_r         <= PW'(kmpp_pkg::MaxLen + 1);
              out_r         <= '{OW'(kmpp_pkg::MaxLen), 1'b0, '0, 1'b1};
              out_valid_r   <= 1'b1;
            end else if (kpos == '0) begin
              pos_r       <= PW'(1);
              k_r         <= '0;
              out_r       <= '{OW'(1), 1'b0, '0, 1'b0};
              out_valid_r <= 1'b1;
            end else if (k_r >= kpos) begin
              k_r <= '0;
            end
          end
        end
        S_CMP: if (k_r != '0 && c_rdata != sym_r) k_r <= k_r;
        S_RDF: k_r <= (f_rdata < k_r) ? f_rdata : '0;
        S_UPD: begin
          k_r   <= match_k;
          pos_r <= upd_len;
          len_r <= upd_len;
        end
        S_OUT: begin
          out_r.prefix_length <= OW'(len_r);
          out_r.overflow      <= 1'b0;
          if (div_r == '0 && div_q > PW'(1)) begin
            out_r.periodic     <= 1'b1;
            out_r.repeat_count <= OW'(div_q);
          end else begin
            out_r.periodic     <= 1'b0;
            out_r.repeat_count <= '0;
          end
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/kmp_periodic_prefix_detector_unit.sv]
// Top level of the periodic prefix detector.
// Each character beat gives one result beat: prefix length, whether the prefix
// is its shortest period repeated at least twice, and the repeat count. A
// character that extends a string has its result ready once the sequencer has
// compared it, walked any failure links (amortised constant per character),
// updated the stores and run the bit-serial division that checks the period.
// The first character of a string and overflowed characters have their result
// presented in the cycle after they are taken. The next character is taken only
// once the sequencer is idle and the last result has left. Throughput is set by
// the one-character-at-a-time sequencer and the one-bit-per-cycle divider; a
// two-beat queue in front lets the sender run ahead. Stores need no clearing.
module kmp_periodic_prefix_detector_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmpp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kmpp_pkg::out_beat_t out_data
);

  logic job_valid, job_ready;
  kmpp_pkg::job_t job;

  kmpp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid, .job_ready, .job
  );

  kmpp_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTHESIS
  // A periodic result always carries a repeat count of two or more.
  a_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.periodic |-> out_data.repeat_count > 17'd1)
    else $error("periodic result with repeat count below two");
  // Overflow results are never periodic.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.periodic)
    else $error("overflow result marked periodic");
  // A job is never taken while a result is still pending.
  a_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |-> !out_valid)
    else $error("job taken with pending result");
`endif

endmodule

[dv/kmpp_checker.sv]
// Checker for the periodic prefix detector: tracks the KMP prefix function and compares results.
module kmpp_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  kmpp_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  kmpp_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import kmpp_pkg::*;

  logic [7:0]      seen_chars [MaxLen];
  logic [PosW-1:0] border_of  [MaxLen+1];
  logic [PosW-1:0] border_len;
  logic [PosW-1:0] str_len;
  out_beat_t       expected_q [$];
  int              periodic_hits;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Work out the result for one character beat and advance the string state.
  function automatic out_beat_t prefix_period(input in_beat_t b);
    out_beat_t       r;
    logic [PosW-1:0] k;
    logic [PosW-1:0] per;
    r = '0;
    if (b.start_new) begin
      str_len = '0;
      border_len = '0;
    end
    if (str_len >= MaxLen) begin
      str_len = PosW'(MaxLen + 1);
      r.prefix_length = OutW'(MaxLen);
      r.overflow = 1'b1;
    end else if (str_len == '0) begin
      seen_chars[0] = b.symbol;
      border_of[0] = '0;
      border_of[1] = '0;
      border_len = '0;
      str_len = PosW'(1);
      r.prefix_length = OutW'(1);
    end else begin
      k = border_len;
      if (k >= str_len) k = '0;
      while (k != '0 && b.symbol != seen_chars[k]) k = (border_of[k] < k) ? border_of[k] : '0;
      k = (b.symbol == seen_chars[k]) ? k + 1'b1 : '0;
      seen_chars[str_len] = b.symbol;
      border_of[str_len+1] = k;
      border_len = k;
      str_len = str_len + 1'b1;
      per = str_len - k;
      r.prefix_length = OutW'(str_len);
      if (per != '0 && str_len % per == '0 && str_len / per > 1) begin
        r.periodic = 1'b1;
        r.repeat_count = OutW'(str_len / per);
      end
    end
    return r;
  endfunction

  // Predict on every accepted character, compare on every accepted result.
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      border_len <= '0;
      str_len <= '0;
      fail_count <= 0;
      periodic_hits <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(prefix_period(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_data.periodic) periodic_hits++;
          if (out_data.prefix_length !== e.prefix_length)
            report("prefix_length", out_data.prefix_length, e.prefix_length);
          if (out_data.periodic !== e.periodic)
            report("periodic", out_data.periodic, e.periodic);
          if (out_data.repeat_count !== e.repeat_count)
            report("repeat_count", out_data.repeat_count, e.repeat_count);
          if (out_data.overflow !== e.overflow)
            report("overflow", out_data.overflow, e.overflow);
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

[dv/tb_top.sv]
// Testbench top for the periodic prefix detector: stimulus, idling phases and verdict.
module tb_top;
  import kmpp_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  int        send_idle_pct;
  int        stall_pct;
  int        hold_cycles;
  int        n_beats;
  int        n_strings;

  kmp_periodic_prefix_detector_unit dut (.*);

  kmpp_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver: random stalls per phase, plus a long hold-off when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one character beat, with random idle cycles before it. Valid stays
  // up after the accepting edge until the next beat or an idle cycle replaces it.
  task automatic send_char(input logic [7:0] sym, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{symbol: sym, start_new: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_beats++;
  endtask

  // A string made of a random block repeated, with an optional broken tail.
  task automatic send_string();
    logic [7:0] blk [8];
    int         plen;
    int         reps;
    int         total;
    plen = $urandom_range(1, 6);
    reps = $urandom_range(1, 5);
    for (int i = 0; i < plen; i++)
      blk[i] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(97, 99));
    total = plen * reps + $urandom_range(0, plen);
    n_strings++;
    for (int i = 0; i < total; i++) begin
      if (i > 0 && $urandom_range(19) == 0)
        send_char(8'($urandom), 1'b0);
      else
        send_char(blk[i % plen], i == 0 && $urandom_range(9) != 0);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    n_beats = 0;
    n_strings = 0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: first beat without a start flag, field extremes, periodic runs.
    send_char(8'h00, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h55, 1'b1);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'h55, 1'b0);
    send_char(8'h55, 1'b1);
    send_char(8'h55, 1'b1);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_cycles = 200;
    for (int i = 0; i < 12; i++) send_char(8'($urandom_range(97, 98)), i == 0);
    wait_drained();

    // Random strings across the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 48 : 38) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 48 : 38) : 0;
      while (n_beats < 27 + (ph + 1) * 110) send_string();
      wait_drained();
    end

    repeat (60) @(negedge clk);
    $display("Sent %0d character beats in %0d strings over four idling phases;",
             n_beats, n_strings);
    $display("%0d periodic results seen; overflow not reachable at this size.",
             u_chk.periodic_hits);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
